### rtl/core/gpqu_pkg.sv
// Package for the grid potential quadratic update block.
// Widths, Q0.16 coefficients and the sideband type carried down the pipeline.
// No dependencies.
package gpqu_pkg;

  localparam int POTENTIAL_WIDTH    = 32;
  localparam int COST_WIDTH         = 16;
  localparam int RATIO_WIDTH        = 16;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = RATIO_WIDTH / DIV_BITS_PER_STAGE;
  localparam int PROD_WIDTH         = 32;
  localparam int ACC_WIDTH          = 33;
  localparam int V_WIDTH            = 17;
  localparam int INC_WIDTH          = COST_WIDTH + 1;

  // quadratic coefficients, Q0.16
  localparam logic [15:0] COEF_A = 16'd15080;
  localparam logic [15:0] COEF_B = 16'd34780;
  localparam logic [15:0] COEF_C = 16'd46137;

  typedef logic [POTENTIAL_WIDTH-1:0] potential_t;
  typedef logic [COST_WIDTH-1:0]      cost_t;
  typedef logic [RATIO_WIDTH-1:0]     ratio_t;

  typedef struct packed {
    potential_t tmin;
    cost_t      cost;
    logic       full;   // dc >= cost: increment is the plain cost
  } side_t;

endpackage

### rtl/core/gpqu_if.sv
// Valid/ready channels of the grid potential quadratic update block.
// Depends on gpqu_pkg.
interface gpqu_req_if;
  logic                 valid;
  logic                 ready;
  gpqu_pkg::potential_t left_potential;
  gpqu_pkg::potential_t right_potential;
  gpqu_pkg::potential_t up_potential;
  gpqu_pkg::potential_t down_potential;
  gpqu_pkg::cost_t      step_cost;

  modport source (
    output valid, left_potential, right_potential, up_potential, down_potential, step_cost,
    input  ready
  );
  modport sink (
    input  valid, left_potential, right_potential, up_potential, down_potential, step_cost,
    output ready
  );
endinterface

interface gpqu_rsp_if;
  logic                 valid;
  logic                 ready;
  gpqu_pkg::potential_t new_potential;
  logic                 saturated;

  modport source (
    output valid, new_potential, saturated,
    input  ready
  );
  modport sink (
    input  valid, new_potential, saturated,
    output ready
  );
endinterface

### rtl/core/gpqu_divider.sv
// Pipelined restoring divider: quotient = (rem << 16) / div, given rem < div.
// Two quotient bits per stage. Depends on gpqu_pkg.
module gpqu_divider (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   in_valid,
  input  gpqu_pkg::cost_t        in_rem,
  input  gpqu_pkg::cost_t        in_div,
  input  gpqu_pkg::side_t        in_side,
  output logic                   out_valid,
  output gpqu_pkg::ratio_t       out_quot,
  output gpqu_pkg::side_t        out_side
);

  typedef struct packed {
    gpqu_pkg::cost_t  rem;
    gpqu_pkg::ratio_t quot;
  } div_state_t;

  function automatic div_state_t div_step(div_state_t s, gpqu_pkg::cost_t d);
    logic [gpqu_pkg::COST_WIDTH:0] trial;
    div_state_t                    t;
    t = s;
    for (int k = 0; k < gpqu_pkg::DIV_BITS_PER_STAGE; k++) begin
      trial = {t.rem, 1'b0};
      if (trial >= {1'b0, d}) begin
        trial  = trial - {1'b0, d};
        t.quot = {t.quot[gpqu_pkg::RATIO_WIDTH-2:0], 1'b1};
      end else begin
        t.quot = {t.quot[gpqu_pkg::RATIO_WIDTH-2:0], 1'b0};
      end
      t.rem = trial[gpqu_pkg::COST_WIDTH-1:0];
    end
    return t;
  endfunction

  logic [gpqu_pkg::DIV_STAGES-1:0] vld;
  div_state_t                      st   [gpqu_pkg::DIV_STAGES];
  gpqu_pkg::cost_t                 dv   [gpqu_pkg::DIV_STAGES];
  gpqu_pkg::side_t                 side [gpqu_pkg::DIV_STAGES];
  div_state_t                      init;

  assign init.rem  = in_rem;
  assign init.quot = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[gpqu_pkg::DIV_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st[0]   <= div_step(init, in_div);
      dv[0]   <= in_div;
      side[0] <= in_side;
      for (int i = 1; i < gpqu_pkg::DIV_STAGES; i++) begin
        st[i]   <= div_step(st[i-1], dv[i-1]);
        dv[i]   <= dv[i-1];
        side[i] <= side[i-1];
      end
    end
  end

  assign out_valid = vld[gpqu_pkg::DIV_STAGES-1];
  assign out_quot  = st[gpqu_pkg::DIV_STAGES-1].quot;
  assign out_side  = side[gpqu_pkg::DIV_STAGES-1];

endmodule

### rtl/core/grid_potential_quadratic_update_top.sv
// Grid potential quadratic update: new cell potential from four neighbors and a cost.
// Top level; depends on gpqu_pkg, gpqu_if (gpqu_req_if, gpqu_rsp_if) and gpqu_divider.
//
// Fully pipelined: one request per cycle while not stalled, through 2 min/difference
// stages, 8 divider stages at two quotient bits each, 4 multiply and accumulate
// stages and 1 add/saturate output register. The whole pipeline moves
// together; it stalls only while a result sits in the output register untaken.
module grid_potential_quadratic_update_top (
  input logic        clk,
  input logic        rst,
  gpqu_req_if.sink   req,
  gpqu_rsp_if.source rsp
);

  localparam int PW = gpqu_pkg::POTENTIAL_WIDTH;

  logic advance;
  assign advance   = !rsp.valid || rsp.ready;
  assign req.ready = advance;

  // stage 1: horizontal and vertical minimum
  logic                 s1_valid;
  gpqu_pkg::potential_t s1_horiz;
  gpqu_pkg::potential_t s1_vert;
  gpqu_pkg::cost_t      s1_cost;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_horiz <= (req.left_potential < req.right_potential) ? req.left_potential
                                                             : req.right_potential;
      s1_vert  <= (req.up_potential < req.down_potential) ? req.up_potential
                                                          : req.down_potential;
      s1_cost  <= req.step_cost;
    end
  end

  // stage 2: difference, smaller minimum, full-cost test
  gpqu_pkg::potential_t dc;
  gpqu_pkg::side_t      s2_side_next;
  logic                 s2_valid;
  gpqu_pkg::side_t      s2_side;
  gpqu_pkg::cost_t      s2_dc;

  always_comb begin
    if (s1_horiz > s1_vert) begin
      dc                = s1_horiz - s1_vert;
      s2_side_next.tmin = s1_vert;
    end else begin
      dc                = s1_vert - s1_horiz;
      s2_side_next.tmin = s1_horiz;
    end
    s2_side_next.cost = s1_cost;
    s2_side_next.full = dc >= PW'(s1_cost);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_side <= s2_side_next;
      s2_dc   <= dc[gpqu_pkg::COST_WIDTH-1:0];
    end
  end

  // ratio = (dc << 16) / cost
  logic             dv_valid;
  gpqu_pkg::ratio_t dv_ratio;
  gpqu_pkg::side_t  dv_side;

  gpqu_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (s2_valid),
    .in_rem    (s2_dc),
    .in_div    (s2_side.cost),
    .in_side   (s2_side),
    .out_valid (dv_valid),
    .out_quot  (dv_ratio),
    .out_side  (dv_side)
  );

  // m1: r*r and B*r
  logic                                m1_valid;
  logic [gpqu_pkg::PROD_WIDTH-1:0]     m1_rsq;
  logic [gpqu_pkg::PROD_WIDTH-1:0]     m1_bterm;
  gpqu_pkg::side_t                     m1_side;
  // m2: A*r2
  logic                                m2_valid;
  logic [gpqu_pkg::PROD_WIDTH-1:0]     m2_aterm;
  logic [gpqu_pkg::PROD_WIDTH-1:0]     m2_bterm;
  gpqu_pkg::side_t                     m2_side;
  logic [gpqu_pkg::PROD_WIDTH:0]       rsq_rnd;
  logic [15:0]                         r2;
  // m3: v
  logic                                m3_valid;
  logic [gpqu_pkg::V_WIDTH-1:0]        m3_v;
  gpqu_pkg::side_t                     m3_side;
  logic [gpqu_pkg::ACC_WIDTH-1:0]      acc;
  logic [gpqu_pkg::ACC_WIDTH-1:0]      acc_rnd;
  // m4: cost * v
  logic                                m4_valid;
  logic [gpqu_pkg::ACC_WIDTH-1:0]      m4_prod;
  gpqu_pkg::side_t                     m4_side;
  // output
  logic [gpqu_pkg::ACC_WIDTH-1:0]      prod_rnd;
  logic [gpqu_pkg::INC_WIDTH-1:0]      inc;
  logic [PW:0]                         sum;
  gpqu_pkg::potential_t                out_tmin;

  always_comb begin
    rsq_rnd = {1'b0, m1_rsq} + (gpqu_pkg::PROD_WIDTH+1)'(32768);
    r2      = rsq_rnd[31:16];
    acc     = {1'b0, gpqu_pkg::COEF_C, 16'b0} + {1'b0, m2_bterm} - {1'b0, m2_aterm};
    acc_rnd = acc + gpqu_pkg::ACC_WIDTH'(32768);
    prod_rnd = m4_prod + gpqu_pkg::ACC_WIDTH'(32768);
    inc     = m4_side.full ? {1'b0, m4_side.cost} : prod_rnd[32:16];
    sum     = {1'b0, m4_side.tmin} + (PW+1)'(inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid  <= 1'b0;
      m2_valid  <= 1'b0;
      m3_valid  <= 1'b0;
      m4_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else if (advance) begin
      m1_valid  <= dv_valid;
      m2_valid  <= m1_valid;
      m3_valid  <= m2_valid;
      m4_valid  <= m3_valid;
      rsp.valid <= m4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m1_rsq            <= {16'b0, dv_ratio} * {16'b0, dv_ratio};
      m1_bterm          <= {16'b0, gpqu_pkg::COEF_B} * {16'b0, dv_ratio};
      m1_side           <= dv_side;
      m2_aterm          <= {16'b0, gpqu_pkg::COEF_A} * {16'b0, r2};
      m2_bterm          <= m1_bterm;
      m2_side           <= m1_side;
      m3_v              <= acc_rnd[32:16];
      m3_side           <= m2_side;
      m4_prod           <= gpqu_pkg::ACC_WIDTH'(m3_side.cost) * gpqu_pkg::ACC_WIDTH'(m3_v);
      m4_side           <= m3_side;
      rsp.new_potential <= sum[PW] ? {PW{1'b1}} : sum[PW-1:0];
      rsp.saturated     <= sum[PW];
      out_tmin          <= m4_side.tmin;
    end
  end

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.saturated |-> &rsp.new_potential)
    else $error("saturated result is not the maximum potential");

  a_not_below_tmin: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.new_potential >= out_tmin)
    else $error("result below smaller neighbor minimum");

  a_v_floor: assert property (@(posedge clk) disable iff (rst)
    m3_valid && !m3_side.full |-> m3_v >= gpqu_pkg::V_WIDTH'(gpqu_pkg::COEF_C))
    else $error("quadratic value below its constant term");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("request taken while result stalled");

  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    dv_valid && !dv_side.full && dv_side.cost == gpqu_pkg::COST_WIDTH'(1)
      |-> dv_ratio == '0)
    else $error("ratio nonzero for unit cost");

endmodule
